// ----- rtl/ssac_pkg.sv -----
// shared types, codes and helpers for the sprite slot allocator
// no dependencies; used by ssac_ctrl, ssac_datapath and the top level
`timescale 1ns / 1ps

package ssac_pkg;

  localparam int unsigned SLOT_COUNT_DEF = 128;
  // slot_sel is 7 bits wide, so the select table has this many rows
  localparam int unsigned SEL_ROWS       = 128;

  typedef enum logic [2:0] {
    ACT_RESTART  = 3'd0,
    ACT_ADD      = 3'd1,
    ACT_RESERVE  = 3'd2,
    ACT_SET_POS  = 3'd3,
    ACT_SET_PROP = 3'd4,
    ACT_FINALIZE = 3'd5,
    ACT_READ     = 3'd6
  } action_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_CLIP = 2'd2;

  localparam logic [1:0] CFG_BACK_TO_FRONT = 2'd0;
  localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd2;

  localparam logic [8:0] SCREEN_WIDTH_RST  = 9'd240;
  localparam logic [7:0] SCREEN_HEIGHT_RST = 8'd160;

  localparam logic [1:0]  SHAPE_TALL   = 2'b10;
  localparam logic [1:0]  SHAPE_WIDE   = 2'b01;
  localparam logic [1:0]  DOUBLE_CODE  = 2'b11;
  localparam logic [15:0] DISABLE_FLAG = 16'h0200;

  typedef struct packed {
    logic accept;     // item taken, store read issued
    logic exec_load;  // modify, write back and load the result
    logic walk;       // finalize: disable one slot
    logic show_load;  // finalize: load the result after the walk
  } ssac_cmd_t;

  typedef struct packed {
    logic is_fin;     // latched item is a finalize
    logic full;       // no slots left
    logic walk_last;  // cursor is at the last free slot
  } ssac_sts_t;

  // sprite span in pixels from size, shape and double bits
  function automatic logic [7:0] span_of(input logic [15:0] p, input logic vert);
    logic [7:0] s;
    logic [1:0] grow;
    logic [1:0] shrink;
    s      = 8'd8 << p[15:14];
    grow   = vert ? SHAPE_TALL : SHAPE_WIDE;
    shrink = vert ? SHAPE_WIDE : SHAPE_TALL;
    if (p[7:6] == grow && s < 8'd32) begin
      s = s << 1;
    end else if (p[7:6] == shrink && s > 8'd8) begin
      s = s >> 1;
    end
    if (p[1:0] == DOUBLE_CODE) begin
      s = s << 1;
    end
    return s;
  endfunction

  // true when the sprite lies wholly outside the visible area
  function automatic logic is_clipped(input logic [9:0] x, input logic [8:0] y,
                                      input logic [15:0] p, input logic [8:0] w,
                                      input logic [7:0] h);
    logic [10:0] xs;
    logic [10:0] ys;
    logic        off_r;
    logic        off_b;
    logic        off_l;
    logic        off_t;
    xs    = {x[9], x} + {3'b000, span_of(p, 1'b0)};
    ys    = {y[8], y[8], y} + {3'b000, span_of(p, 1'b1)};
    off_r = !x[9] && (x[8:0] >= w);
    off_b = !y[8] && (y[7:0] >= h);
    off_l = xs[10] || (xs == 11'd0);
    off_t = ys[10] || (ys == 11'd0);
    return off_r || off_b || off_l || off_t;
  endfunction

endpackage

// ----- rtl/ssac_ctrl.sv -----
// sequencer of the sprite slot allocator: item intake, execute, finalize walk
// depends on ssac_pkg (command and status structs)
`timescale 1ns / 1ps

module ssac_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  ssac_pkg::ssac_sts_t sts,
  output ssac_pkg::ssac_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_SHOW
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.is_fin && !sts.full) begin
          state_nxt = S_WALK;
        end else if (out_free) begin
          cmd.exec_load = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_last) begin
          state_nxt = S_SHOW;
        end
      end
      S_SHOW: begin
        if (out_free) begin
          cmd.show_load = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // a result load must never overwrite a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec_load || cmd.show_load) |-> !(out_valid_r && out_stall))
    else $error("result loaded over a pending result");

  // the walk only runs while free slots remain
  a_walk_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> !sts.full)
    else $error("finalize walk with no free slot");

  // an accepted item reaches the execute state in the next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (state_r == S_EXEC))
    else $error("accepted item not executed");

endmodule

// ----- rtl/ssac_datapath.sv -----
// datapath of the sprite slot allocator: attribute store, cursor, config, result
// depends on ssac_pkg (codes, span and clip helpers, command and status structs)
`timescale 1ns / 1ps

module ssac_datapath #(
  parameter int unsigned SLOT_COUNT = ssac_pkg::SLOT_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [8:0]          cfg_data,
  input  logic [2:0]          in_action,
  input  logic [9:0]          in_pos_x,
  input  logic [8:0]          in_pos_y,
  input  logic [9:0]          in_tile_image,
  input  logic [23:0]         in_prop_word,
  input  logic [6:0]          in_slot_sel,
  input  ssac_pkg::ssac_cmd_t cmd,
  output ssac_pkg::ssac_sts_t sts,
  output logic [1:0]          out_status,
  output logic [6:0]          out_slot_index,
  output logic [15:0]         out_attr_zero,
  output logic [15:0]         out_attr_one,
  output logic [15:0]         out_attr_two,
  output logic [7:0]          out_slots_left
);

  localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOT_COUNT - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(SLOT_COUNT);
  localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(SLOT_COUNT - 1);

  // config
  logic       btf_r;
  logic [8:0] scr_w_r;
  logic [7:0] scr_h_r;

  // allocation state
  logic             dir_r;
  logic             dir_nxt;
  logic [CNT_W-1:0] cursor_r;
  logic [CNT_W-1:0] cursor_nxt;
  logic [IDX_W-1:0] cslot;
  logic [IDX_W-1:0] last_slot_r;

  // latched item
  ssac_pkg::action_t act_r;
  logic [9:0]        x_r;
  logic [8:0]        y_r;
  logic [9:0]        tile_r;
  logic [23:0]       prop_r;
  logic [IDX_W-1:0]  sel_r;

  // attribute store, one array per attribute
  logic [15:0]      mem0 [SLOT_COUNT];
  logic [15:0]      mem1 [SLOT_COUNT];
  logic [15:0]      mem2 [SLOT_COUNT];
  logic [15:0]      q0_r;
  logic [15:0]      q1_r;
  logic [15:0]      q2_r;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] acc_addr;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] ex_addr;
  logic             we0;
  logic             we1;
  logic             we2;
  logic             ex_we0;
  logic             ex_we1;
  logic             ex_we2;
  logic [15:0]      n0;
  logic [15:0]      n1;
  logic [15:0]      n2;
  logic [15:0]      dis0;
  logic [15:0]      dis1;

  // result
  logic [1:0]       res_status;
  logic [IDX_W-1:0] res_slot;
  logic             res_show;
  logic             ex_step;
  logic [IDX_W+6:0] slot_ext;
  logic [CNT_W-1:0] left_cnt;
  logic [CNT_W+7:0] left_ext;
  logic [1:0]       out_status_r;
  logic [6:0]       out_slot_r;
  logic [15:0]      out_a0_r;
  logic [15:0]      out_a1_r;
  logic [15:0]      out_a2_r;
  logic [7:0]       out_left_r;

  logic             clip_add;
  logic             clip_pos;
  logic [15:0]      q_prop;
  logic [15:0]      add0;
  logic [15:0]      add1;
  logic [15:0]      add2;

  // slot_sel modulo slot count, as a constant table
  logic [IDX_W-1:0] sel_tab [ssac_pkg::SEL_ROWS];

  for (genvar i = 0; i < ssac_pkg::SEL_ROWS; i++) begin : g_sel
    localparam int unsigned SEL_MOD = i % SLOT_COUNT;
    assign sel_tab[i] = IDX_W'(SEL_MOD);
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      btf_r   <= 1'b0;
      scr_w_r <= ssac_pkg::SCREEN_WIDTH_RST;
      scr_h_r <= ssac_pkg::SCREEN_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ssac_pkg::CFG_BACK_TO_FRONT: btf_r   <= cfg_data[0];
        ssac_pkg::CFG_SCREEN_WIDTH:  scr_w_r <= cfg_data;
        ssac_pkg::CFG_SCREEN_HEIGHT: scr_h_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign cslot = dir_r ? (LAST_SLOT - cursor_r[IDX_W-1:0]) : cursor_r[IDX_W-1:0];
  assign dis0  = ssac_pkg::DISABLE_FLAG | {8'h00, scr_h_r};
  assign dis1  = {7'b0000000, scr_w_r};

  assign sts.is_fin    = (act_r == ssac_pkg::ACT_FINALIZE);
  assign sts.full      = (cursor_r >= CNT_FULL);
  assign sts.walk_last = (cursor_r == CNT_LAST);

  // store read: at intake, or the slot being disabled during the walk
  assign acc_addr = (in_action == ssac_pkg::ACT_ADD || in_action == ssac_pkg::ACT_RESERVE)
                    ? cslot : sel_tab[in_slot_sel];
  assign rd_en    = cmd.accept || cmd.walk;
  assign rd_addr  = cmd.walk ? cslot : acc_addr;

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r  <= ssac_pkg::action_t'(in_action);
      x_r    <= in_pos_x;
      y_r    <= in_pos_y;
      tile_r <= in_tile_image;
      prop_r <= in_prop_word;
      sel_r  <= sel_tab[in_slot_sel];
    end
  end

  // packed attributes and clip tests
  assign add0     = {prop_r[7:0], y_r[7:0]};
  assign add1     = {prop_r[15:8], 8'h00} | {7'b0000000, x_r[8:0]};
  assign add2     = {prop_r[23:16], 8'h00} | {6'b000000, tile_r};
  assign q_prop   = {q1_r[15:8], q0_r[15:8]};
  assign clip_add = ssac_pkg::is_clipped(x_r, y_r, prop_r[15:0], scr_w_r, scr_h_r);
  assign clip_pos = ssac_pkg::is_clipped(x_r, y_r, q_prop, scr_w_r, scr_h_r);

  // execute step of one item
  always_comb begin
    res_status = ssac_pkg::ST_OK;
    res_slot   = '0;
    res_show   = 1'b0;
    ex_addr    = cslot;
    ex_we0     = 1'b0;
    ex_we1     = 1'b0;
    ex_we2     = 1'b0;
    n0         = q0_r;
    n1         = q1_r;
    n2         = q2_r;
    ex_step    = 1'b0;
    dir_nxt    = dir_r;
    case (act_r)
      ssac_pkg::ACT_RESTART: begin
        dir_nxt  = btf_r;
        res_slot = btf_r ? LAST_SLOT : '0;
      end
      ssac_pkg::ACT_ADD: begin
        if (sts.full) begin
          res_status = ssac_pkg::ST_FULL;
        end else if (clip_add) begin
          res_status = ssac_pkg::ST_CLIP;
          res_slot   = cslot;
        end else begin
          res_slot = cslot;
          res_show = 1'b1;
          ex_step  = 1'b1;
          {ex_we0, ex_we1, ex_we2} = 3'b111;
          n0 = add0;
          n1 = add1;
          n2 = add2;
        end
      end
      ssac_pkg::ACT_RESERVE: begin
        if (sts.full) begin
          res_status = ssac_pkg::ST_FULL;
        end else begin
          res_slot = cslot;
          res_show = 1'b1;
          ex_step  = 1'b1;
          {ex_we0, ex_we1} = 2'b11;
          n0 = dis0;
          n1 = dis1;
        end
      end
      ssac_pkg::ACT_SET_POS: begin
        ex_addr  = sel_r;
        res_slot = sel_r;
        res_show = 1'b1;
        {ex_we0, ex_we1} = 2'b11;
        if (clip_pos) begin
          res_status = ssac_pkg::ST_CLIP;
          n0 = dis0;
          n1 = dis1;
        end else begin
          n0 = {q0_r[15:8], y_r[7:0]};
          n1 = {q1_r[15:9], x_r[8:0]};
        end
      end
      ssac_pkg::ACT_SET_PROP: begin
        ex_addr  = sel_r;
        res_slot = sel_r;
        res_show = 1'b1;
        {ex_we0, ex_we1, ex_we2} = 3'b111;
        n0 = {prop_r[7:0], q0_r[7:0]};
        n1 = {prop_r[15:8], 8'h00} | {7'b0000000, q1_r[8:0]};
        n2 = add2;
      end
      ssac_pkg::ACT_READ: begin
        res_slot = sel_r;
        res_show = 1'b1;
      end
      default: ;
    endcase
  end

  // write port: the execute step or the finalize walk
  assign we0     = (cmd.exec_load && ex_we0) || cmd.walk;
  assign we1     = (cmd.exec_load && ex_we1) || cmd.walk;
  assign we2     = cmd.exec_load && ex_we2;
  assign wr_addr = cmd.walk ? cslot : ex_addr;

  always_ff @(posedge clk) begin
    if (we0) begin
      mem0[wr_addr] <= cmd.walk ? dis0 : n0;
    end
    if (rd_en) begin
      q0_r <= mem0[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (we1) begin
      mem1[wr_addr] <= cmd.walk ? dis1 : n1;
    end
    if (rd_en) begin
      q1_r <= mem1[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (we2) begin
      mem2[wr_addr] <= n2;
    end
    if (rd_en) begin
      q2_r <= mem2[rd_addr];
    end
  end

  // cursor and direction
  always_comb begin
    cursor_nxt = cursor_r;
    if (cmd.exec_load && act_r == ssac_pkg::ACT_RESTART) begin
      cursor_nxt = '0;
    end else if ((cmd.exec_load && ex_step) || cmd.walk) begin
      cursor_nxt = cursor_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
      dir_r    <= 1'b0;
    end else begin
      cursor_r <= cursor_nxt;
      if (cmd.exec_load) begin
        dir_r <= dir_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk) begin
      last_slot_r <= cslot;
    end
  end

  // result register
  assign left_cnt = CNT_FULL - cursor_nxt;
  assign left_ext = {8'h00, left_cnt};
  assign slot_ext = {7'b0000000, cmd.show_load ? last_slot_r : res_slot};

  always_ff @(posedge clk) begin
    if (cmd.show_load) begin
      out_status_r <= ssac_pkg::ST_OK;
      out_slot_r   <= slot_ext[6:0];
      out_a0_r     <= dis0;
      out_a1_r     <= dis1;
      out_a2_r     <= q2_r;
      out_left_r   <= left_ext[7:0];
    end else if (cmd.exec_load) begin
      out_status_r <= res_status;
      out_slot_r   <= slot_ext[6:0];
      out_a0_r     <= res_show ? n0 : 16'h0000;
      out_a1_r     <= res_show ? n1 : 16'h0000;
      out_a2_r     <= res_show ? n2 : 16'h0000;
      out_left_r   <= left_ext[7:0];
    end
  end

  assign out_status     = out_status_r;
  assign out_slot_index = out_slot_r;
  assign out_attr_zero  = out_a0_r;
  assign out_attr_one   = out_a1_r;
  assign out_attr_two   = out_a2_r;
  assign out_slots_left = out_left_r;

  // the cursor never runs past the slot count
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= CNT_FULL)
    else $error("cursor beyond slot count");

  // the last walk step leaves the store full
  a_walk_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.walk && sts.walk_last) |=> sts.full)
    else $error("finalize walk ended with free slots");

  // restart rewinds the cursor
  a_restart_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec_load && act_r == ssac_pkg::ACT_RESTART) |=> (cursor_r == '0))
    else $error("restart did not clear the cursor");

endmodule

// ----- rtl/sprite_slot_allocator_clip.sv -----
// top level of the sprite slot allocator with clipping
// depends on ssac_pkg, ssac_ctrl and ssac_datapath
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// in_       input      in_valid / in_stall    action, pos_x, pos_y, tile_image,
//                                            prop_word, slot_sel
// out_      output     out_valid / out_stall  status, slot_index, attr_zero,
//                                            attr_one, attr_two, slots_left
// cfg_      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// sequence: store read at intake, modify and write back in the execute step;
//   finalize walks any free slots, one per cycle, then loads the result
// reset: synchronous on rst_n low; cursor to zero, front to back fill,
//   screen 240 x 160; store contents stay undefined until written
// stalls: a finished result waits in the output register while the next item
//   is taken in; the execute step holds only if that register is still full
// config: cfg_ready is always high; the user must make writes only while the
//   block is idle, which the block itself does not enforce

module sprite_slot_allocator_clip #(
  parameter int unsigned SLOT_COUNT = ssac_pkg::SLOT_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration write
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data,
  // item input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_action,
  input  logic signed [9:0]  in_pos_x,
  input  logic signed [8:0]  in_pos_y,
  input  logic [9:0]         in_tile_image,
  input  logic [23:0]        in_prop_word,
  input  logic [6:0]         in_slot_sel,
  // result output
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [6:0]         out_slot_index,
  output logic [15:0]        out_attr_zero,
  output logic [15:0]        out_attr_one,
  output logic [15:0]        out_attr_two,
  output logic [7:0]         out_slots_left
);

  ssac_pkg::ssac_cmd_t cmd;
  ssac_pkg::ssac_sts_t sts;
  logic                cfg_we;

  // config is written straight into registers, so the port never pushes back
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // sequencer: intake, execute, finalize walk, result hand-off
  ssac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // store, cursor, clip logic and result register
  ssac_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_action      (in_action),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_tile_image  (in_tile_image),
    .in_prop_word   (in_prop_word),
    .in_slot_sel    (in_slot_sel),
    .cmd            (cmd),
    .sts            (sts),
    .out_status     (out_status),
    .out_slot_index (out_slot_index),
    .out_attr_zero  (out_attr_zero),
    .out_attr_one   (out_attr_one),
    .out_attr_two   (out_attr_two),
    .out_slots_left (out_slots_left)
  );

endmodule

// ----- test/testbench.sv -----
// self-checking testbench for sprite_slot_allocator_clip, the sprite slot allocator
// depends on ssac_pkg and the rtl top level; checks every result against a built-in predictor
`timescale 1ns / 1ps

module testbench;
  import ssac_pkg::*;

  localparam int SLOTS = SLOT_COUNT_DEF;
  // action code that the block ignores
  localparam logic [2:0] ACT_UNUSED = 3'd7;

  typedef struct {
    logic [2:0]  act;
    logic [9:0]  px;
    logic [8:0]  py;
    logic [9:0]  tile;
    logic [23:0] prop;
    logic [6:0]  sel;
  } sprite_cmd_t;

  typedef struct {
    logic [1:0]  status;
    logic [6:0]  slot;
    logic [15:0] a0;
    logic [15:0] a1;
    logic [15:0] a2;
    logic [7:0]  left;
  } sprite_res_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [8:0]  cfg_data;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_action = '0;
  logic [9:0]  in_pos_x = '0;
  logic [8:0]  in_pos_y = '0;
  logic [9:0]  in_tile_image = '0;
  logic [23:0] in_prop_word = '0;
  logic [6:0]  in_slot_sel = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [6:0]  out_slot_index;
  logic [15:0] out_attr_zero;
  logic [15:0] out_attr_one;
  logic [15:0] out_attr_two;
  logic [7:0]  out_slots_left;

  sprite_slot_allocator_clip uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_tile_image  (in_tile_image),
    .in_prop_word   (in_prop_word),
    .in_slot_sel    (in_slot_sel),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_slot_index (out_slot_index),
    .out_attr_zero  (out_attr_zero),
    .out_attr_one   (out_attr_one),
    .out_attr_two   (out_attr_two),
    .out_slots_left (out_slots_left)
  );

  // ---------------------------------------------------------------------------
  // shadow of the block: attribute store, allocation cursor and screen setup
  // ---------------------------------------------------------------------------
  logic [15:0] sprite_mem [SLOTS][3];
  int          fill_cnt = 0;       // slots handed out since the last restart
  logic        fill_dir = 1'b0;    // direction latched at restart
  logic        b2f_cfg  = 1'b0;
  logic [8:0]  sw_cfg   = SCREEN_WIDTH_RST;
  logic [7:0]  sh_cfg   = SCREEN_HEIGHT_RST;

  // bookkeeping
  sprite_cmd_t pending_cmds [$];   // items waiting for the driver
  sprite_res_t expected_res [$];   // predicted results in order
  sprite_cmd_t drv_cmd;
  sprite_cmd_t seen_cmd;
  sprite_res_t want;
  int          items_queued = 0;
  int          items_taken = 0;
  int          results_checked = 0;
  int          full_seen = 0;
  int          clip_seen = 0;
  int          settings_seen = 0;
  int          fail_cnt = 0;
  int          send_gap = 0;
  int          stall_left = 0;
  logic        squeeze_done = 1'b0;
  logic [31:0] cyc = '0;
  logic        calm;

  // a quarter of the time neither side idles
  assign calm = (cyc[8:7] == 2'b00);

  // sprite extent in pixels from the size, shape and double bits
  function automatic int sprite_span(input logic [15:0] p, input logic vert);
    int         s;
    logic [1:0] grow;
    logic [1:0] shrink;
    s      = 8 << p[15:14];
    grow   = vert ? SHAPE_TALL : SHAPE_WIDE;
    shrink = vert ? SHAPE_WIDE : SHAPE_TALL;
    // prohibited shape matches neither and stays square
    if (p[7:6] == grow && s < 32) s = s * 2;
    else if (p[7:6] == shrink && s > 8) s = s / 2;
    if (p[1:0] == DOUBLE_CODE) s = s * 2;
    return s;
  endfunction

  function automatic logic off_screen(input int x, input int y, input logic [15:0] p);
    return x >= int'(sw_cfg) || y >= int'(sh_cfg) ||
           x <= -sprite_span(p, 1'b0) || y <= -sprite_span(p, 1'b1);
  endfunction

  function automatic logic [6:0] next_slot();
    return fill_dir ? 7'(SLOTS - 1 - fill_cnt) : 7'(fill_cnt);
  endfunction

  // disabled entry: parked at the screen corner, tile word kept
  function automatic void park_entry(input logic [6:0] s);
    sprite_mem[s][0] = 16'(sh_cfg) | DISABLE_FLAG;
    sprite_mem[s][1] = 16'(sw_cfg);
  endfunction

  // applies one item to the shadow state and returns the result it causes
  function automatic sprite_res_t apply_cmd(input sprite_cmd_t c);
    sprite_res_t r;
    int          xi;
    int          yi;
    logic [15:0] q;
    logic        show;
    r    = '{default: '0};
    show = 1'b0;
    xi   = int'($signed(c.px));
    yi   = int'($signed(c.py));
    case (c.act)
      ACT_RESTART: begin
        fill_dir = b2f_cfg;
        fill_cnt = 0;
        r.slot   = next_slot();
      end
      ACT_ADD, ACT_RESERVE: begin
        if (fill_cnt >= SLOTS) begin
          r.status = ST_FULL;
        end else begin
          r.slot = next_slot();
          if (c.act == ACT_ADD && off_screen(xi, yi, c.prop[15:0])) begin
            // clipped add: nothing written, cursor stays
            r.status = ST_CLIP;
          end else begin
            if (c.act == ACT_ADD) begin
              sprite_mem[r.slot][0] = {c.prop[7:0], c.py[7:0]};
              sprite_mem[r.slot][1] = 16'(c.px[8:0]) | {c.prop[15:8], 8'h00};
              sprite_mem[r.slot][2] = 16'(c.tile) | {c.prop[23:16], 8'h00};
            end else begin
              park_entry(r.slot);
            end
            fill_cnt++;
            show = 1'b1;
          end
        end
      end
      ACT_SET_POS: begin
        q      = {sprite_mem[c.sel][1][15:8], sprite_mem[c.sel][0][15:8]};
        r.slot = c.sel;
        show   = 1'b1;
        if (off_screen(xi, yi, q)) begin
          park_entry(c.sel);
          r.status = ST_CLIP;
        end else begin
          sprite_mem[c.sel][0] = {sprite_mem[c.sel][0][15:8], c.py[7:0]};
          sprite_mem[c.sel][1] = 16'(c.px[8:0]) | (sprite_mem[c.sel][1] & 16'hFE00);
        end
      end
      ACT_SET_PROP: begin
        sprite_mem[c.sel][0] = {c.prop[7:0], sprite_mem[c.sel][0][7:0]};
        sprite_mem[c.sel][1] = (sprite_mem[c.sel][1] & 16'h01FF) | {c.prop[15:8], 8'h00};
        sprite_mem[c.sel][2] = 16'(c.tile) | {c.prop[23:16], 8'h00};
        r.slot = c.sel;
        show   = 1'b1;
      end
      ACT_FINALIZE: begin
        // every slot still free gets disabled; the last one is shown
        while (fill_cnt < SLOTS) begin
          r.slot = next_slot();
          park_entry(r.slot);
          fill_cnt++;
          show = 1'b1;
        end
      end
      ACT_READ: begin
        r.slot = c.sel;
        show   = 1'b1;
      end
      default: begin
      end
    endcase
    if (show) begin
      r.a0 = sprite_mem[r.slot][0];
      r.a1 = sprite_mem[r.slot][1];
      r.a2 = sprite_mem[r.slot][2];
    end
    r.left = 8'(SLOTS - fill_cnt);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  // idle lengths: mostly short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic sprite_cmd_t make_cmd(input logic [2:0] act, input int x, input int y,
                                           input int tile, input int prop, input int sel);
    sprite_cmd_t c;
    c.act  = act;
    c.px   = 10'(x);
    c.py   = 9'(y);
    c.tile = 10'(tile);
    c.prop = 24'(prop);
    c.sel  = 7'(sel);
    return c;
  endfunction

  // positions cluster around the screen edges so both clip outcomes show up
  function automatic int rand_x();
    case ($urandom_range(0, 3))
      0: return int'($urandom_range(0, 1023)) - 512;
      1: return -int'($urandom_range(0, 140));
      2: return int'(sw_cfg) - 2 + int'($urandom_range(0, 3));
      default: return int'($urandom_range(0, int'(sw_cfg) - 1));
    endcase
  endfunction

  function automatic int rand_y();
    case ($urandom_range(0, 3))
      0: return int'($urandom_range(0, 511)) - 256;
      1: return -int'($urandom_range(0, 260));
      2: return int'(sh_cfg) - 2 + int'($urandom_range(0, 3));
      default: return int'($urandom_range(0, int'(sh_cfg) - 1));
    endcase
  endfunction

  function automatic sprite_cmd_t rand_cmd(input logic [2:0] act);
    return make_cmd(act, rand_x(), rand_y(), $urandom_range(0, 1023), $urandom,
                    $urandom_range(0, 127));
  endfunction

  task automatic queue_cmd(input sprite_cmd_t c);
    pending_cmds.push_back(c);
    items_queued++;
  endtask

  // one frame build: restart, a run of allocations and edits, mostly a finalize
  task automatic queue_frame();
    int         n;
    int         r;
    logic [2:0] act;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(120, 140) : $urandom_range(3, 50);
    queue_cmd(rand_cmd(ACT_RESTART));
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 60) act = ACT_ADD;
      else if (r < 72) act = ACT_RESERVE;
      else if (r < 82) act = ACT_SET_POS;
      else if (r < 90) act = ACT_SET_PROP;
      else act = ACT_READ;
      queue_cmd(rand_cmd(act));
    end
    if ($urandom_range(0, 5) != 0) queue_cmd(rand_cmd(ACT_FINALIZE));
  endtask

  // unordered actions, the unused code among them
  task automatic queue_noise();
    repeat ($urandom_range(1, 8)) queue_cmd(rand_cmd(3'($urandom_range(0, 7))));
  endtask

  task automatic wait_idle();
    while (items_taken != items_queued || expected_res.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_BACK_TO_FRONT: b2f_cfg = val[0];
      CFG_SCREEN_WIDTH:  sw_cfg  = val;
      CFG_SCREEN_HEIGHT: sh_cfg  = val[7:0];
      default: begin
      end
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic set_screen(input logic b2f, input int w, input int h);
    wait_idle();
    write_reg(CFG_BACK_TO_FRONT, 9'(b2f));
    write_reg(CFG_SCREEN_WIDTH, 9'(w));
    write_reg(CFG_SCREEN_HEIGHT, 9'(h));
    settings_seen++;
  endtask

  task automatic check_field(input string what, input int exp_val, input int got_val);
    if (exp_val != got_val) begin
      fail_cnt++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, exp_val,
               got_val);
    end
  endtask

  // ---------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // driver: takes items from pending_cmds, holds the payload while stalled
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (in_valid && in_stall) begin
      // item not taken yet, keep it on the port
    end else if (send_gap != 0) begin
      in_valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_cmds.size() != 0) begin
      drv_cmd        = pending_cmds.pop_front();
      in_action     <= drv_cmd.act;
      in_pos_x      <= drv_cmd.px;
      in_pos_y      <= drv_cmd.py;
      in_tile_image <= drv_cmd.tile;
      in_prop_word  <= drv_cmd.prop;
      in_slot_sel   <= drv_cmd.sel;
      in_valid      <= 1'b1;
      // gap that follows once this item is taken
      send_gap      <= (calm || $urandom_range(0, 2) != 0) ? 0 : gap_len();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls plus one long hold-off so the block backs up
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!squeeze_done && items_taken >= 250) begin
      // long hold-off while the driver keeps offering items
      squeeze_done <= 1'b1;
      out_stall    <= 1'b1;
      stall_left   <= 399;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= gap_len() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks results in order, predicts each accepted item
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_res.size() == 0) begin
          fail_cnt++;
          $display("%0t ns: result with none expected, expected nothing, actual slot %0h",
                   $time, out_slot_index);
        end else begin
          want = expected_res.pop_front();
          check_field("status", want.status, out_status);
          check_field("slot_index", want.slot, out_slot_index);
          check_field("attr_zero", want.a0, out_attr_zero);
          check_field("attr_one", want.a1, out_attr_one);
          check_field("attr_two", want.a2, out_attr_two);
          check_field("slots_left", want.left, out_slots_left);
          results_checked++;
          if (want.status == ST_FULL) full_seen++;
          if (want.status == ST_CLIP) clip_seen++;
        end
      end
      // a result can never leave on the edge its item arrives, so order is safe
      if (in_valid && !in_stall) begin
        seen_cmd.act  = in_action;
        seen_cmd.px   = in_pos_x;
        seen_cmd.py   = in_pos_y;
        seen_cmd.tile = in_tile_image;
        seen_cmd.prop = in_prop_word;
        seen_cmd.sel  = in_slot_sel;
        expected_res.push_back(apply_cmd(seen_cmd));
        items_taken <= items_taken + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_BACK_TO_FRONT;
    cfg_data  = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // fill every slot with a visible sprite first, so no entry is ever read unwritten
    queue_cmd(make_cmd(ACT_RESTART, 0, 0, 0, 0, 0));
    queue_cmd(make_cmd(ACT_ADD, 0, 0, 0, 0, 0));
    queue_cmd(make_cmd(ACT_ADD, 239, 159, 1023, 24'hFFFFFF, 127));
    for (int i = 2; i < SLOTS; i++) begin
      queue_cmd(make_cmd(ACT_ADD, $urandom_range(0, 239), $urandom_range(0, 159),
                         $urandom_range(0, 1023), $urandom, $urandom_range(0, 127)));
    end

    // store full on add and reserve
    queue_cmd(make_cmd(ACT_ADD, 10, 10, 5, 24'h123456, 0));
    queue_cmd(make_cmd(ACT_RESERVE, 0, 0, 0, 0, 0));
    queue_cmd(make_cmd(ACT_READ, 0, 0, 0, 0, 0));
    queue_cmd(make_cmd(ACT_READ, 0, 0, 0, 0, 127));
    queue_cmd(make_cmd(ACT_SET_PROP, 0, 0, 1023, 24'hFFFFFF, 5));
    // slot 6 becomes an 8x8 sprite, then is pushed over each screen edge
    queue_cmd(make_cmd(ACT_SET_PROP, 0, 0, 0, 0, 6));
    queue_cmd(make_cmd(ACT_SET_POS, -7, -7, 0, 0, 6));
    queue_cmd(make_cmd(ACT_SET_POS, -8, 0, 0, 0, 6));
    queue_cmd(make_cmd(ACT_SET_POS, 0, -8, 0, 0, 6));
    queue_cmd(make_cmd(ACT_SET_POS, 240, 0, 0, 0, 6));
    queue_cmd(make_cmd(ACT_SET_POS, 0, 160, 0, 0, 6));
    queue_cmd(make_cmd(ACT_SET_POS, 239, 159, 0, 0, 6));
    // prohibited shape with size 16 stays 16x16
    queue_cmd(make_cmd(ACT_SET_PROP, 0, 0, 7, 24'h0040C0, 7));
    queue_cmd(make_cmd(ACT_SET_POS, -15, -15, 0, 0, 7));
    queue_cmd(make_cmd(ACT_SET_POS, -16, 0, 0, 0, 7));
    // largest tall sprite, doubled: 64 wide, 128 high
    queue_cmd(make_cmd(ACT_SET_PROP, 0, 0, 9, 24'h00C083, 8));
    queue_cmd(make_cmd(ACT_SET_POS, -63, -127, 0, 0, 8));
    queue_cmd(make_cmd(ACT_SET_POS, -512, -256, 0, 0, 8));
    // clipped add, doubled add, reserve, then finalize twice
    queue_cmd(make_cmd(ACT_RESTART, 0, 0, 0, 0, 0));
    queue_cmd(make_cmd(ACT_ADD, 240, 0, 1, 0, 0));
    queue_cmd(make_cmd(ACT_ADD, -31, -31, 2, 24'h004003, 0));
    queue_cmd(make_cmd(ACT_RESERVE, 511, 255, 0, 0, 0));
    queue_cmd(make_cmd(ACT_FINALIZE, 0, 0, 0, 0, 0));
    queue_cmd(make_cmd(ACT_FINALIZE, 0, 0, 0, 0, 0));
    queue_cmd(make_cmd(ACT_UNUSED, -1, -1, 1023, 24'hFFFFFF, 127));
    queue_cmd(make_cmd(ACT_READ, 0, 0, 0, 0, 1));

    // random frame builds under a series of screen setups, extremes included
    for (int ph = 0; ph < 7; ph++) begin
      int phase_end;
      case (ph)
        0: set_screen(1'b1, 511, 255);
        1: set_screen(1'b0, 1, 1);
        2: set_screen(1'b1, 240, 160);
        3: set_screen(1'b0, $urandom_range(2, 510), $urandom_range(2, 254));
        4: set_screen(1'b1, 1, 255);
        5: set_screen(1'b0, 511, 1);
        default: set_screen(1'b1, $urandom_range(1, 511), $urandom_range(1, 255));
      endcase
      phase_end = items_queued + 150;
      while (items_queued < phase_end) begin
        if ($urandom_range(0, 9) == 0) queue_noise();
        else queue_frame();
      end
    end

    // drain, then allow the pipeline to settle
    wait_idle();
    repeat (20) @(posedge clk);
    $display("checked %0d results from %0d items across %0d screen setups",
             results_checked, items_taken, settings_seen);
    $display("%0d of them reported a full store and %0d a clipped sprite",
             full_seen, clip_seen);
    if (fail_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // overall limit on run length
  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
